FILE: hw/rtl/scf_pkg.sv
package scf_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 19;
  localparam int COEF_W    = 22;
  localparam int INV_W     = 17;
  localparam int SEG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_POINTS = 16;
  localparam int K_W        = $clog2(MAX_POINTS);

  // twice-value coefficients: at most 9 * 2^SAMPLE_W in magnitude
  localparam int TWICE_W = SAMPLE_W + 6;
  localparam int PROD_W  = TWICE_W + INV_W + 1;

  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);

  localparam logic [INV_W-1:0] INV_RESET = INV_W'(1 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_INV_STRIDE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INV_STRIDE_SQ   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INV_STRIDE_CUBE = CFG_IDX_W'(2);

  // what the closing or current point produces
  typedef enum logic [1:0] {
    KIND_FEW,     // bin of a single point
    KIND_LINEAR,  // bin of two points
    KIND_FIRST,   // first (quadratic) segment
    KIND_INNER    // Catmull-Rom segment
  } kind_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] w0;
    logic [SAMPLE_W-1:0] w1;
    logic [SAMPLE_W-1:0] w2;
    logic [SAMPLE_W-1:0] y;
    logic [K_W-1:0]      k;
    kind_t               kind;
    logic                pair;  // closing quadratic segment follows
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  typedef struct packed {
    logic [INV_W-1:0] lin;
    logic [INV_W-1:0] quad;
    logic [INV_W-1:0] cubic;
  } scale_t;

endpackage

FILE: hw/rtl/scf_front.sv
module scf_front import scf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] ratio,
  input  logic                last_point,
  input  logic                q_full,
  output logic                push,
  output job_t                push_job
);

  logic [SAMPLE_W-1:0] window [3];
  logic [K_W-1:0]      points_seen;
  logic [K_W:0]        kp;
  logic                accept;
  logic                bin_end;
  kind_t               kind;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign kp       = {1'b0, points_seen};
  assign bin_end  = last_point || (points_seen == K_W'(MAX_POINTS - 1));

  always_comb begin
    priority if (kp == (K_W+1)'(0)) begin
      kind = KIND_FEW;
    end else if (kp == (K_W+1)'(1)) begin
      kind = KIND_LINEAR;
    end else if (kp == (K_W+1)'(2)) begin
      kind = KIND_FIRST;
    end else begin
      kind = KIND_INNER;
    end
  end

  // results come only once a segment is complete or the bin closes
  assign push          = accept && (bin_end || kp >= (K_W+1)'(2));
  assign push_job.w0   = window[0];
  assign push_job.w1   = window[1];
  assign push_job.w2   = window[2];
  assign push_job.y    = ratio;
  assign push_job.k    = points_seen;
  assign push_job.kind = kind;
  assign push_job.pair = bin_end && kp >= (K_W+1)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= '0;
    end else if (accept) begin
      points_seen <= bin_end ? '0 : points_seen + K_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window[0] <= '0;
      window[1] <= '0;
      window[2] <= '0;
    end else if (accept) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= ratio;
    end
  end

endmodule

FILE: hw/rtl/scf_queue.sv
module scf_queue import scf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  job_t            mem [QDEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign full       = (count == (QA_W+1)'(QDEPTH));
  assign head.valid = (count != '0);
  assign head.job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QA_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QA_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QA_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/scf_back.sv
module scf_back import scf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_head_t           head,
  output logic              pop,
  input  scale_t            scale,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SEG_W-1:0]  segment,
  output logic [COEF_W-1:0] coef_cubic,
  output logic [COEF_W-1:0] coef_quad,
  output logic [COEF_W-1:0] coef_lin,
  output logic [COEF_W-1:0] coef_const,
  output logic              last_segment,
  output logic              too_few_points
);

  localparam logic [PROD_W:0] LIM_POS  = (PROD_W+1)'(2**(COEF_W-1) - 1);
  localparam logic [PROD_W:0] LIM_NEG  = (PROD_W+1)'(2**(COEF_W-1));
  localparam logic [PROD_W:0] HALF_LSB = (PROD_W+1)'(2**FRAC_BITS);

  // round to nearest, halves away from zero, drop FRAC_BITS+1 bits, saturate
  function automatic logic [COEF_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W:0]   r;
    logic [COEF_W-1:0] res;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    r   = ({1'b0, mag} + HALF_LSB) >> (FRAC_BITS + 1);
    if (!p[PROD_W-1]) begin
      res = (r > LIM_POS) ? LIM_POS[COEF_W-1:0] : r[COEF_W-1:0];
    end else begin
      res = (r >= LIM_NEG) ? LIM_NEG[COEF_W-1:0] : COEF_W'(-r);
    end
    return res;
  endfunction

  function automatic logic signed [TWICE_W-1:0] ext(input logic [SAMPLE_W-1:0] s);
    return $signed({{(TWICE_W-SAMPLE_W){1'b0}}, s});
  endfunction

  // issue stage
  logic                       sub;
  logic                       issue;
  logic                       out_en, s2_en, s1_en;
  logic signed [TWICE_W-1:0]  w0, w1, w2, yy, s2, m0, m1;
  logic signed [TWICE_W-1:0]  a2_n, b2_n, c2_n;
  logic [SAMPLE_W-1:0]        d_n;
  logic [SEG_W-1:0]           seg_n;
  logic                       last_n, few_n;
  logic [K_W:0]               kx;

  // stage 1: twice-value coefficients
  logic                       v1;
  logic signed [TWICE_W-1:0]  a2, b2, c2;
  logic [SAMPLE_W-1:0]        d1;
  logic [SEG_W-1:0]           seg1;
  logic                       last1, few1;

  // stage 2: scaled products
  logic                       v2;
  logic signed [PROD_W-1:0]   pa, pb, pc;
  logic [SAMPLE_W-1:0]        d2;
  logic [SEG_W-1:0]           seg2;
  logic                       last2, few2;

  assign out_en = !out_valid || !out_stall;
  assign s2_en  = !v2 || out_en;
  assign s1_en  = !v1 || s2_en;
  assign issue  = head.valid && s1_en;
  assign pop    = issue && (!head.job.pair || sub);

  assign w0 = ext(head.job.w0);
  assign w1 = ext(head.job.w1);
  assign w2 = ext(head.job.w2);
  assign yy = ext(head.job.y);
  assign s2 = yy - w1;
  assign m0 = w2 - w0;
  assign m1 = yy - w1;
  assign kx = {1'b0, head.job.k};

  always_comb begin
    a2_n   = '0;
    b2_n   = '0;
    c2_n   = '0;
    d_n    = '0;
    seg_n  = '0;
    last_n = 1'b0;
    few_n  = 1'b0;
    if (sub) begin
      // closing quadratic, slope fixed at its inner end
      b2_n   = (yy <<< 1) - (w2 <<< 1) - s2;
      c2_n   = s2;
      d_n    = head.job.w2;
      seg_n  = SEG_W'(kx - (K_W+1)'(1));
      last_n = 1'b1;
    end else begin
      unique case (head.job.kind)
        KIND_FEW: begin
          last_n = 1'b1;
          few_n  = 1'b1;
        end
        KIND_LINEAR: begin
          c2_n   = (yy - w2) <<< 1;
          d_n    = head.job.w2;
          last_n = 1'b1;
        end
        KIND_FIRST: begin
          b2_n = (w1 <<< 1) - (w2 <<< 1) + s2;
          c2_n = (w2 <<< 2) - (w1 <<< 2) - s2;
          d_n  = head.job.w1;
        end
        KIND_INNER: begin
          a2_n  = (w1 <<< 2) - (w2 <<< 2) + m0 + m1;
          b2_n  = (w2 <<< 2) + (w2 <<< 1) - (w1 <<< 2) - (w1 <<< 1) - (m0 <<< 1) - m1;
          c2_n  = m0;
          d_n   = head.job.w1;
          seg_n = SEG_W'(kx - (K_W+1)'(2));
        end
        default: begin
          few_n = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        sub <= head.job.pair && !sub;
      end
      if (s1_en) begin
        v1 <= issue;
      end
      if (s2_en) begin
        v2 <= v1;
      end
      if (out_en) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a2    <= a2_n;
      b2    <= b2_n;
      c2    <= c2_n;
      d1    <= d_n;
      seg1  <= seg_n;
      last1 <= last_n;
      few1  <= few_n;
    end
    if (s2_en && v1) begin
      pa    <= a2 * $signed({1'b0, scale.cubic});
      pb    <= b2 * $signed({1'b0, scale.quad});
      pc    <= c2 * $signed({1'b0, scale.lin});
      d2    <= d1;
      seg2  <= seg1;
      last2 <= last1;
      few2  <= few1;
    end
    if (out_en && v2) begin
      coef_cubic     <= round_sat(pa);
      coef_quad      <= round_sat(pb);
      coef_lin       <= round_sat(pc);
      coef_const     <= COEF_W'(d2);
      segment        <= seg2;
      last_segment   <= last2;
      too_few_points <= few2;
    end
  end

`ifndef SYNTHESIS
  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_few_points |-> last_segment && coef_cubic == '0 &&
      coef_quad == '0 && coef_lin == '0 && coef_const == '0)
    else $error("single-point bin result not cleared");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("queue popped while empty");

  a_pair_second: assert property (@(posedge clk) disable iff (rst)
    issue && head.job.pair && !sub |=> sub && head.valid)
    else $error("closing segment of a pair lost");
`endif

endmodule

FILE: hw/rtl/spline_coeff_fitter.sv
// A result reaches the output register through the queue write, the coefficient stage, the
//   multiply stage and the round/saturate stage.
// Throughput: one item per cycle unless in_stall; a closing point after two or more points
//   yields two segments via the single output register; a 4-deep job queue absorbs them.
// Reset (rst, synchronous, active high): clears bin count, queue, pipeline valids and
//   sets all three reciprocal strides to 1.0.
module spline_coeff_fitter import scf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // sample channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  ratio,
  input  logic                 last_point,
  // coefficient channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SEG_W-1:0]     segment,
  output logic [COEF_W-1:0]    coef_cubic,
  output logic [COEF_W-1:0]    coef_quad,
  output logic [COEF_W-1:0]    coef_lin,
  output logic [COEF_W-1:0]    coef_const,
  output logic                 last_segment,
  output logic                 too_few_points,
  // configuration writes
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [INV_W-1:0]     cfg_data
);

  scale_t  scale;
  logic    push;
  job_t    push_job;
  logic    q_full;
  logic    pop;
  q_head_t head;

  // Reciprocal strides, unsigned Q1.16. Any 17-bit value is taken as given;
  // writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale.lin   <= INV_RESET;
      scale.quad  <= INV_RESET;
      scale.cubic <= INV_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INV_STRIDE:      scale.lin   <= cfg_data;
        REG_INV_STRIDE_SQ:   scale.quad  <= cfg_data;
        REG_INV_STRIDE_CUBE: scale.cubic <= cfg_data;
        default: begin
          scale.lin <= scale.lin;
        end
      endcase
    end
  end

  // Front end: keeps the three-sample window and the point count of the
  // current bin, classifies each point and queues a job when it completes
  // a segment or closes the bin. Stalls only when the queue is full.
  scf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .ratio      (ratio),
    .last_point (last_point),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Job queue: lets the front keep taking samples while the back end is
  // emitting the second segment of a closing point or the consumer stalls.
  scf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  // Back end: per job, one or two segments; twice-value coefficients, then
  // the stride multiplies, then rounding and Q5.16 saturation.
  scf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .pop            (pop),
    .scale          (scale),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .segment        (segment),
    .coef_cubic     (coef_cubic),
    .coef_quad      (coef_quad),
    .coef_lin       (coef_lin),
    .coef_const     (coef_const),
    .last_segment   (last_segment),
    .too_few_points (too_few_points)
  );

endmodule
